[src/cssd_pkg.sv]
// Package for the CSS escape decoder: word types, decoder modes, queue sizing
// and the UTF-8 encoding function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cssd_pkg;

    localparam int MAX_HEX_DIGITS = 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [23:0] CP_MAX         = 24'h10FFFF;
    localparam logic [23:0] CP_SURR_LO     = 24'h00D800;
    localparam logic [23:0] CP_SURR_HI     = 24'h00DFFF;
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_LIMIT1      = 21'h00007F;
    localparam logic [20:0] CP_LIMIT2      = 21'h0007FF;
    localparam logic [20:0] CP_LIMIT3      = 21'h00FFFF;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4     = 8'hF0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } out_word_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_CR_SKIP
    } mode_t;

    // One queued command: the UTF-8 bytes of a code point, then a literal byte.
    typedef struct packed {
        logic [3:0][7:0] enc_bytes;
        logic [2:0]      enc_n;
        logic            lit_v;
        logic [7:0]      lit;
        logic            fin;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            h.value = b[4:0] - 5'h10;
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            h.value = {2'b0, b[2:0]} + 5'd9;
        else
            h.valid = 1'b0;
        return h;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_FF;
    endfunction

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } enc_t;

    function automatic enc_t utf8_encode(input logic [23:0] cp_raw);
        enc_t       e;
        logic       bad;
        logic [20:0] cp;
        bad = cp_raw == 24'd0 || cp_raw > CP_MAX
              || (cp_raw >= CP_SURR_LO && cp_raw <= CP_SURR_HI);
        cp = bad ? CP_REPLACEMENT : cp_raw[20:0];
        e.bytes = '0;
        if (cp <= CP_LIMIT1) begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.n = 3'd1;
        end else if (cp <= CP_LIMIT2) begin
            e.bytes[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
            e.bytes[1] = UTF8_CONT | {2'b0, cp[5:0]};
            e.n = 3'd2;
        end else if (cp <= CP_LIMIT3) begin
            e.bytes[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
            e.bytes[1] = UTF8_CONT | {2'b0, cp[11:6]};
            e.bytes[2] = UTF8_CONT | {2'b0, cp[5:0]};
            e.n = 3'd3;
        end else begin
            e.bytes[0] = UTF8_LEAD4 | {5'b0, cp[20:18]};
            e.bytes[1] = UTF8_CONT | {2'b0, cp[17:12]};
            e.bytes[2] = UTF8_CONT | {2'b0, cp[11:6]};
            e.bytes[3] = UTF8_CONT | {2'b0, cp[5:0]};
            e.n = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

[src/css_escape_decoder_core.sv]
// Top level of the CSS escape decoder: front end, command queue, back end.
// Depends on cssd_pkg, cssd_front, cssd_queue and cssd_back.
//
// Input channel text_valid / text_stall / text: one word per raw byte of a
// CSS string, with final_byte set on the last byte of the string.
// Output channel dec_valid / dec_stall / dec: one word per decoded byte.
// A multi-byte UTF-8 code point plus the byte that ended its escape gives
// up to five words; run_last marks the last word of an input byte and
// string_end marks words from the final byte. A final byte that yields no
// data gives one bare end-marker word (byte_valid low).
// The first word of an input byte reaches dec through the command queue
// and the back end's output register. Throughput: one output word per
// cycle while dec_stall is low, set by the back end's single output register;
// bytes that give one or no word go at one per cycle. Bytes that give several
// words fill the four-entry command queue; text_stall rises while it is full.
// Reset (rst_n low, asynchronous): decoder returns to literal mode, queue
// empties, dec_valid drops. While dec_stall is high the output word holds.
`timescale 1ns / 1ps
`default_nettype none

module css_escape_decoder_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                text_valid,
    output logic                     text_stall,
    input  wire cssd_pkg::in_word_t  text,
    output logic                     dec_valid,
    input  wire logic                dec_stall,
    output cssd_pkg::out_word_t      dec
);
    import cssd_pkg::*;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head;

    // Hold off new bytes while the queue has no room.
    assign text_stall = full;
    assign accept     = text_valid && !full;

    cssd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .word   (text),
        .accept (accept),
        .push   (push),
        .cmd    (push_cmd)
    );

    cssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Advance through the head command one word per cycle while dec_stall is low.
    cssd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dec_valid  (dec_valid),
        .dec        (dec),
        .dec_stall  (dec_stall)
    );

endmodule

`default_nettype wire

[src/cssd_front.sv]
// Front end of the CSS escape decoder: escape state machine and command build.
// Depends on cssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cssd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cssd_pkg::in_word_t word,
    input  wire logic             accept,
    output logic                  push,
    output cssd_pkg::cmd_t        cmd
);
    import cssd_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [23:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_comb begin
        logic [7:0]  b;
        hex_t        h;
        logic        emit_cp;
        logic [23:0] cp;
        logic        lit_v;
        logic        do_plain;
        enc_t        e;

        b        = word.in_byte;
        h        = hex_digit(b);
        emit_cp  = 1'b0;
        cp       = acc_reg;
        lit_v    = 1'b0;
        do_plain = 1'b0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;

        unique case (mode_reg)
            MODE_NORMAL: do_plain = 1'b1;
            MODE_ESCAPE: begin
                if (b == CH_CR)
                    mode_next = MODE_CR_SKIP;
                else if (b == CH_LF || b == CH_FF)
                    mode_next = MODE_NORMAL;
                else if (h.valid) begin
                    acc_next  = {20'd0, h.value[3:0]};
                    cnt_next  = 3'd1;
                    mode_next = MODE_HEX;
                end else begin
                    lit_v     = 1'b1;
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_HEX: begin
                if (h.valid && cnt_reg < 3'(MAX_HEX_DIGITS)) begin
                    acc_next = {acc_reg[19:0], h.value[3:0]};
                    cnt_next = cnt_reg + 3'd1;
                end else begin
                    emit_cp  = 1'b1;
                    acc_next = '0;
                    cnt_next = '0;
                    if (is_ws(b))
                        mode_next = (b == CH_CR) ? MODE_CR_SKIP : MODE_NORMAL;
                    else
                        do_plain = 1'b1;
                end
            end
            MODE_CR_SKIP: begin
                if (b == CH_LF)
                    mode_next = MODE_NORMAL;
                else
                    do_plain = 1'b1;
            end
            default: do_plain = 1'b1;
        endcase

        if (do_plain) begin
            if (b == CH_BACKSLASH)
                mode_next = MODE_ESCAPE;
            else begin
                mode_next = MODE_NORMAL;
                lit_v     = 1'b1;
            end
        end

        // End of string: flush a pending code point and drop everything else.
        if (word.final_byte) begin
            if (mode_next == MODE_HEX) begin
                emit_cp = 1'b1;
                cp      = acc_next;
            end
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
        end

        e             = utf8_encode(cp);
        cmd.enc_bytes = e.bytes;
        cmd.enc_n     = emit_cp ? e.n : 3'd0;
        cmd.lit_v     = lit_v;
        cmd.lit       = b;
        cmd.fin       = word.final_byte;
        push          = accept && (emit_cp || lit_v || word.final_byte);
    end

endmodule

`default_nettype wire

[src/cssd_queue.sv]
// Command queue between the decoder front and back ends.
// Depends on cssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cssd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cssd_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output cssd_pkg::cmd_t      head
);
    import cssd_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? QPTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

[src/cssd_back.sv]
// Back end of the CSS escape decoder: expands one command into result words.
// Depends on cssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cssd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire cssd_pkg::cmd_t  head,
    output logic                 pop,
    output logic                 dec_valid,
    output cssd_pkg::out_word_t  dec,
    input  wire logic            dec_stall
);
    import cssd_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    out_word_t  word_reg, word_next;
    logic       emit;
    logic [2:0] total;
    logic       marker;
    logic       last;

    assign dec_valid = valid_reg;
    assign dec       = word_reg;

    always_comb begin
        total  = head.enc_n + {2'b0, head.lit_v};
        marker = total == 3'd0;
        last   = marker || (pos_reg == total - 3'd1);
        emit   = head_valid && (!valid_reg || !dec_stall);
        pop    = emit && last;

        word_next.out_byte   = marker ? 8'd0
                             : (pos_reg < head.enc_n) ? head.enc_bytes[pos_reg[1:0]]
                             : head.lit;
        word_next.byte_valid = !marker;
        word_next.run_last   = last;
        word_next.string_end = head.fin;

        pos_next   = emit ? (last ? 3'd0 : pos_reg + 3'd1) : pos_reg;
        valid_next = emit ? 1'b1 : (valid_reg && dec_stall);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (emit)
            word_reg <= word_next;
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for css_escape_decoder_core: raw CSS text bytes in,
// decoded bytes out, each word checked against a predictor kept in this file.
// Depends on cssd_pkg and the RTL of css_escape_decoder_core.
`timescale 1ns / 1ps

module tb_top;

    import cssd_pkg::*;

    localparam int          RANDOM_BYTES = 150;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          LONG_HOLD    = 150;  // receiver hold-off, in cycles
    localparam int          SHOW_MAX     = 10;

    // Sources of text bytes waiting for the driver. A set drain_first flag
    // holds the word back until every decoded word owed so far has come out.
    typedef struct {
        in_word_t w;
        bit       drain_first;
    } text_item_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_stall;
    in_word_t  text       = '0;
    logic      dec_valid;
    logic      dec_stall  = 1'b0;
    out_word_t dec;

    text_item_t  text_q[$];     // bytes still to be offered
    out_word_t   decoded_q[$];  // decoded words owed by the block, oldest first
    logic [7:0]  cp_bytes[$];   // bytes produced by one input byte

    // Shadow of the decoder state
    mode_t       dec_mode  = MODE_NORMAL;
    logic [23:0] cp_acc    = '0;
    logic [2:0]  n_digits  = '0;

    int          err_count = 0;
    int          shown     = 0;
    int unsigned cycle_count = 0;

    css_escape_decoder_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .dec_valid  (dec_valid),
        .dec_stall  (dec_stall),
        .dec        (dec)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int hex_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    // Vertical tab does not count as CSS whitespace.
    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_FF;
    endfunction

    // Emit one code point as UTF-8; zero, surrogates and anything past the
    // Unicode range turn into the replacement character.
    task automatic put_code_point(input logic [23:0] raw);
        logic [20:0] cp;
        if (raw == 24'd0 || raw > 24'h10FFFF || (raw >= 24'h00D800 && raw <= 24'h00DFFF))
            cp = 21'h00FFFD;
        else
            cp = raw[20:0];
        if (cp <= 21'h7F)
            cp_bytes.push_back({1'b0, cp[6:0]});
        else if (cp <= 21'h7FF)
        begin
            cp_bytes.push_back({3'b110, cp[10:6]});
            cp_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp <= 21'hFFFF)
        begin
            cp_bytes.push_back({4'b1110, cp[15:12]});
            cp_bytes.push_back({2'b10, cp[11:6]});
            cp_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            cp_bytes.push_back({5'b11110, cp[20:18]});
            cp_bytes.push_back({2'b10, cp[17:12]});
            cp_bytes.push_back({2'b10, cp[11:6]});
            cp_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    // A byte seen in literal context: a backslash opens an escape, anything
    // else passes straight through.
    task automatic take_plain(input logic [7:0] b);
        if (b == CH_BACKSLASH)
            dec_mode = MODE_ESCAPE;
        else
        begin
            dec_mode = MODE_NORMAL;
            cp_bytes.push_back(b);
        end
    endtask

    // Advance the shadow state by one accepted text word and queue the
    // decoded words it owes.
    task automatic decode_byte(input in_word_t w);
        logic [7:0] b;
        int         hv;
        out_word_t  r;
        b  = w.in_byte;
        hv = hex_val(b);
        cp_bytes.delete();
        case (dec_mode)
            MODE_ESCAPE:
            begin
                if (b == CH_CR)
                    dec_mode = MODE_CR_SKIP;
                else if (b == CH_LF || b == CH_FF)
                    dec_mode = MODE_NORMAL;         // line continuation: drop both
                else if (hv >= 0)
                begin
                    cp_acc   = 24'(hv);
                    n_digits = 3'd1;
                    dec_mode = MODE_HEX;
                end
                else
                begin
                    cp_bytes.push_back(b);          // escaped non-hex byte stands for itself
                    dec_mode = MODE_NORMAL;
                end
            end
            MODE_HEX:
            begin
                if (hv >= 0 && n_digits < MAX_HEX_DIGITS)
                begin
                    cp_acc   = {cp_acc[19:0], hv[3:0]};
                    n_digits = n_digits + 3'd1;
                end
                else
                begin
                    // Escape ends here: flush the code point, swallow one
                    // whitespace byte (CR may pair with a following LF).
                    put_code_point(cp_acc);
                    cp_acc   = '0;
                    n_digits = '0;
                    if (is_blank(b))
                        dec_mode = (b == CH_CR) ? MODE_CR_SKIP : MODE_NORMAL;
                    else
                        take_plain(b);
                end
            end
            MODE_CR_SKIP:
            begin
                if (b == CH_LF)
                    dec_mode = MODE_NORMAL;
                else
                    take_plain(b);
            end
            default:
                take_plain(b);
        endcase

        // End of string: flush a pending code point and drop everything else.
        if (w.final_byte)
        begin
            if (dec_mode == MODE_HEX)
                put_code_point(cp_acc);
            dec_mode = MODE_NORMAL;
            cp_acc   = '0;
            n_digits = '0;
            if (cp_bytes.size() == 0)
            begin
                r.out_byte   = 8'h00;
                r.byte_valid = 1'b0;
                r.run_last   = 1'b1;
                r.string_end = 1'b1;
                decoded_q.push_back(r);
            end
        end

        foreach (cp_bytes[k])
        begin
            r.out_byte   = cp_bytes[k];
            r.byte_valid = 1'b1;
            r.run_last   = (k == cp_bytes.size() - 1);
            r.string_end = w.final_byte;
            decoded_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Idle pattern: pct is the chance of a gap; most gaps are short, a
    // few are long.
    // ------------------------------------------------------------------
    function automatic int rand_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer text words from text_q, predict each one on accept.
    // ------------------------------------------------------------------
    int tx_gap   = 0;
    bit tx_burst = 1'b0;  // stretch with no idling on the sender

    always @(posedge clk)
    begin : drive_text
        text_item_t nxt;
        if (!rst_n)
            text_valid <= 1'b0;
        else
        begin
            if (text_valid && !text_stall)
                decode_byte(text);
            // Hold the payload while stalled; otherwise the slot is free.
            if (!text_valid || !text_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    text_valid <= 1'b0;
                end
                else if (text_q.size() != 0
                         && !(text_q[0].drain_first && decoded_q.size() != 0))
                begin
                    nxt = text_q.pop_front();
                    text       <= nxt.w;
                    text_valid <= 1'b1;
                    tx_gap = rand_gap(tx_burst ? 0 : 35);
                    if ($urandom_range(0, 39) == 0)
                        tx_burst = !tx_burst;
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall on the output, plus one long hold-off once
    // enough words have passed so that the queue fills and text_stall rises.
    // ------------------------------------------------------------------
    int rx_left   = 0;
    int rx_taken  = 0;
    bit rx_burst  = 1'b0;
    bit long_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            dec_stall <= 1'b0;
        else
        begin
            if (dec_valid && !dec_stall)
                rx_taken++;
            if (rx_left > 0)
            begin
                rx_left--;
                dec_stall <= 1'b1;
            end
            else if (!long_done && rx_taken >= 40)
            begin
                long_done = 1'b1;
                rx_left   = LONG_HOLD - 1;
                dec_stall <= 1'b1;
            end
            else
            begin
                rx_left = rand_gap(rx_burst ? 0 : 25);
                if (rx_left > 0)
                    rx_left--;
                dec_stall <= (rx_left > 0) || !rx_burst && $urandom_range(0, 9) == 0;
                if ($urandom_range(0, 59) == 0)
                    rx_burst = !rx_burst;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted decoded word with the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_decoded
        out_word_t want;
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                err_count++;
                if (shown < SHOW_MAX)
                begin
                    shown++;
                    $display("unexpected word: byte %h valid %b last %b end %b",
                             dec.out_byte, dec.byte_valid, dec.run_last, dec.string_end);
                end
            end
            else
            begin
                want = decoded_q.pop_front();
                if (dec.out_byte !== want.out_byte || dec.byte_valid !== want.byte_valid
                    || dec.run_last !== want.run_last || dec.string_end !== want.string_end)
                begin
                    err_count++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display("mismatch: got byte %h valid %b last %b end %b, want %h %b %b %b",
                                 dec.out_byte, dec.byte_valid, dec.run_last, dec.string_end,
                                 want.out_byte, want.byte_valid, want.run_last,
                                 want.string_end);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input bit fin = 1'b0);
        text_item_t it;
        it.w.in_byte    = b;
        it.w.final_byte = fin;
        it.drain_first  = 1'b0;
        text_q.push_back(it);
    endtask

    task automatic add_text(input string s, input bit fin = 1'b0);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], fin && i == s.len() - 1);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    // One random chunk of CSS text; mostly well-formed escapes with random
    // content, some raw noise.
    task automatic add_random_chunk();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    add_byte(8'($urandom_range(0, 255)));
            end
            2, 3, 4, 5, 9:
            begin
                add_byte(CH_BACKSLASH);
                n = ($urandom_range(0, 7) == 0) ? 7 : $urandom_range(1, 6);
                repeat (n)
                    add_byte(hex_char($urandom_range(0, 15)));
                case ($urandom_range(0, 7))
                    0: add_byte(CH_SPACE);
                    1: add_byte(CH_TAB);
                    2: add_byte(CH_LF);
                    3: add_byte(CH_CR);
                    4:
                    begin
                        add_byte(CH_CR);
                        add_byte(CH_LF);
                    end
                    5: add_byte(CH_FF);
                    6: add_byte(8'($urandom_range(0, 255)));
                    default: ;
                endcase
            end
            6:
            begin
                add_byte(CH_BACKSLASH);
                do
                    b = 8'($urandom_range(0, 255));
                while (hex_val(b) >= 0);
                add_byte(b);
            end
            7:
            begin
                add_byte(CH_BACKSLASH);
                case ($urandom_range(0, 3))
                    0: add_byte(CH_LF);
                    1: add_byte(CH_FF);
                    2: add_byte(CH_CR);
                    default:
                    begin
                        add_byte(CH_CR);
                        add_byte(CH_LF);
                    end
                endcase
            end
            default:
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        endcase
        // Close the string now and then.
        if ($urandom_range(0, 5) == 0)
            text_q[$].w.final_byte = 1'b1;
    endtask

    initial
    begin : run
        int n_directed;

        // Directed: line continuations, zero code point with CR not followed
        // by LF, six-digit maximum plus a seventh digit, surrogate with a
        // swallowed space, byte extremes, lone backslash at the end, and a
        // hex escape cut short by the end of the string.
        add_byte(CH_BACKSLASH);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_BACKSLASH);
        add_byte(CH_FF);
        add_text("\\0");
        add_byte(CH_CR);
        add_text("Z");
        add_text("\\10FFFF7");
        add_text("\\d800 ");
        add_byte(8'hFF);
        add_byte(8'h00, 1'b1);
        add_byte(CH_BACKSLASH, 1'b1);
        add_text("\\e9", 1'b1);
        n_directed = text_q.size();

        while (text_q.size() < n_directed + RANDOM_BYTES)
            add_random_chunk();
        // Let the pipe run dry before the random part and once midway.
        text_q[n_directed].drain_first      = 1'b1;
        text_q[n_directed + 90].drain_first = 1'b1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last text word to go in, then for every decoded word.
        while (text_q.size() != 0 || text_valid)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[css_escape_decoder_core.f]
src/cssd_pkg.sv
src/cssd_front.sv
src/cssd_queue.sv
src/cssd_back.sv
src/css_escape_decoder_core.sv
tb/tb_top.sv
